// ===== sv/banked_free_list_allocator_macros.svh =====
// Assertion macros used by the allocator module.
`ifndef BANKED_FREE_LIST_ALLOCATOR_MACROS_SVH
`define BANKED_FREE_LIST_ALLOCATOR_MACROS_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BFLA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BFLA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/bfla_pkg.sv =====
// Types, codes and defaults of the banked free-list allocator.
package bfla_pkg;

    localparam int DEF_NUM_BANKS  = 8;
    localparam int DEF_NODE_COUNT = 256;

    localparam int BUSY_BANKS   = 8;
    localparam int BUSY_IW      = $clog2(BUSY_BANKS);
    localparam int OVF_BUSY_BIT = 8;
    localparam int APB_AW       = 2;
    localparam int APB_DW       = 32;

    typedef logic [1:0] t_opcode;
    typedef logic [2:0] t_req_id;
    typedef logic [7:0] t_node_in;
    typedef logic [8:0] t_count;
    typedef logic [8:0] t_busy;
    typedef logic [1:0] t_status;
    typedef logic [7:0] t_node_out;
    typedef logic [3:0] t_list;
    typedef logic [3:0] t_banks;

    localparam t_opcode OP_PUSH     = 2'd0;
    localparam t_opcode OP_POP      = 2'd1;
    localparam t_opcode OP_POPULATE = 2'd2;
    localparam t_opcode OP_UNUSED   = 2'd3;

    localparam t_status ST_DONE   = 2'd0;
    localparam t_status ST_EMPTY  = 2'd1;
    localparam t_status ST_REJECT = 2'd2;

    localparam t_list  LIST_NONE   = 4'd0;
    localparam t_list  LIST_OVF    = 4'd8;
    localparam t_banks BANKS_RESET = 4'd8;

    localparam logic [APB_AW-1:0] ADDR_BANKS = 2'd0;

endpackage

// ===== sv/bfla_req_if.sv =====
// Request channel of the allocator: opcode, requester, node, count and busy mask.
interface bfla_req_if;
    logic               valid;
    logic               ready;
    bfla_pkg::t_opcode  opcode;
    bfla_pkg::t_req_id  requester;
    bfla_pkg::t_node_in node_index;
    bfla_pkg::t_count   populate_count;
    bfla_pkg::t_busy    busy_mask;

    modport source (
        output valid, opcode, requester, node_index, populate_count, busy_mask,
        input  ready
    );
    modport sink (
        input  valid, opcode, requester, node_index, populate_count, busy_mask,
        output ready
    );
endinterface

// ===== sv/bfla_rsp_if.sv =====
// Response channel of the allocator: status, node taken and list used.
interface bfla_rsp_if;
    logic                valid;
    logic                ready;
    bfla_pkg::t_status   status;
    bfla_pkg::t_node_out node_out;
    bfla_pkg::t_list     list_used;

    modport source (
        output valid, status, node_out, list_used,
        input  ready
    );
    modport sink (
        input  valid, status, node_out, list_used,
        output ready
    );
endinterface

// ===== sv/banked_free_list_allocator.sv =====
// Banked free-list allocator: per-bank LIFO lists and an overflow list over one link memory.
//
// Requests arrive on i_req as valid/ready transfers; every request gives exactly one
// response transfer on o_rsp. Opcodes are push, pop and populate; a requester at or
// above the banks in use is rejected with a status and no change of state.
// The block works on one request at a time. Push reads the bank head, then writes the link
// and head; pop reads the head, reads the link, then writes the head; reject and unused
// opcode go straight to the reply. A new request is accepted in the cycle after the edge that
// registers the response. Populate splits its count by repeated subtraction and then
// writes one link per cycle.
// The bank heads sit in a small memory with a flip-flop valid bit per bank; the
// link memory needs no clearing, since a link is always written before it is read.
// After reset all lists are empty and banks_in_use is 8; no clearing pass is needed.
// A response waits in the output register while the receiver stalls; the next request is
// still accepted, but its last step (for push and pop the final write-back) then waits
// until the register frees. The APB port holds banks_in_use at address 0; pready is always
// high. The user must write only while the block is idle; the block does not enforce it.
`include "banked_free_list_allocator_macros.svh"

module banked_free_list_allocator #(
    parameter int NUM_BANKS  = bfla_pkg::DEF_NUM_BANKS,
    parameter int NODE_COUNT = bfla_pkg::DEF_NODE_COUNT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    bfla_req_if.sink                      i_req,
    bfla_rsp_if.source                    o_rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bfla_pkg::APB_AW-1:0]   paddr,
    input  logic [bfla_pkg::APB_DW-1:0]   pwdata,
    output logic [bfla_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    localparam int BW       = (NUM_BANKS > 1) ? $clog2(NUM_BANKS) : 1;
    localparam int BW1      = $clog2(NUM_BANKS + 1);
    localparam int NW       = $clog2(NODE_COUNT);
    localparam int LW       = NW + 1;
    localparam int CNTW     = $clog2(NODE_COUNT + 1);
    localparam int NODE_INS = 2 ** $bits(bfla_pkg::t_node_in);

    localparam int SW = 4;
    localparam logic [SW-1:0] S_IDLE  = 4'd0;
    localparam logic [SW-1:0] S_PUSH  = 4'd1;
    localparam logic [SW-1:0] S_PHEAD = 4'd2;
    localparam logic [SW-1:0] S_PLINK = 4'd3;
    localparam logic [SW-1:0] S_DIV   = 4'd4;
    localparam logic [SW-1:0] S_PBANK = 4'd5;
    localparam logic [SW-1:0] S_PGET  = 4'd6;
    localparam logic [SW-1:0] S_PFILL = 4'd7;
    localparam logic [SW-1:0] S_REPLY = 4'd8;

    typedef logic [NODE_INS-1:0][NW-1:0] t_nmod_tbl;

    function automatic t_nmod_tbl build_nmod();
        t_nmod_tbl tbl;
        for (int i = 0; i < NODE_INS; i++) begin
            tbl[i] = NW'(i % NODE_COUNT);
        end
        return tbl;
    endfunction

    localparam t_nmod_tbl NODE_MOD = build_nmod();

    logic [SW-1:0]          r_state, n_state;
    bfla_pkg::t_banks       r_banks;
    logic [NUM_BANKS-1:0]   r_ne, n_ne;
    logic                   r_ovf_ne, n_ovf_ne;
    logic [NW-1:0]          r_ovf_idx, n_ovf_idx;
    logic [BW-1:0]          r_bank, n_bank;
    logic                   r_ovf, n_ovf;
    logic [NW-1:0]          r_node, n_node;
    logic [CNTW-1:0]        r_q, n_q;
    logic [CNTW-1:0]        r_rem, n_rem;
    logic [CNTW-1:0]        r_left, n_left;
    logic [BW1-1:0]         r_b, n_b;
    logic [NW-1:0]          r_next, n_next;
    logic [LW-1:0]          r_cur, n_cur;
    bfla_pkg::t_status      r_rstat, n_rstat;

    logic                   r_ov, n_ov;
    bfla_pkg::t_status      r_status, n_status;
    bfla_pkg::t_node_out    r_nout, n_nout;
    bfla_pkg::t_list        r_used, n_used;

    logic [NW-1:0]          r_head_mem [NUM_BANKS];
    logic [NW-1:0]          r_hrd;
    logic                   w_hre, w_hwe;
    logic [BW-1:0]          w_hra;
    logic [NW-1:0]          w_hwd;

    logic [LW-1:0]          r_link_mem [NODE_COUNT];
    logic [LW-1:0]          r_lrd;
    logic                   w_lre, w_lwe;
    logic [NW-1:0]          w_lra, w_lwa;
    logic [LW-1:0]          w_lwd;

    logic [BW1-1:0]                     w_nb;
    logic                               w_req_ok;
    logic [bfla_pkg::BUSY_BANKS-1:0]    w_mask_banks;
    logic [NUM_BANKS-1:0]               w_busy;
    logic [NUM_BANKS-1:0]               w_elig;
    logic                               w_found;
    logic [BW-1:0]                      w_sel;
    logic [NW-1:0]                      w_node;
    logic [CNTW-1:0]                    w_cnt_sat;
    logic [CNTW-1:0]                    w_quota;
    logic                               w_can_out;
    logic                               w_cfg_wr;
    logic                               w_req_xfer;
    logic                               w_pop_bank;
    logic                               w_rsp_fail;
    logic                               w_rsp_clean;

    assign w_cfg_wr = psel && penable && pwrite && (paddr == bfla_pkg::ADDR_BANKS);
    assign pready   = 1'b1;
    assign prdata   = (paddr == bfla_pkg::ADDR_BANKS) ?
                      bfla_pkg::APB_DW'(r_banks) : '0;

    always_comb begin
        if (r_banks == '0) begin
            w_nb = BW1'(1);
        end else if (32'(r_banks) > NUM_BANKS) begin
            w_nb = BW1'(NUM_BANKS);
        end else begin
            w_nb = BW1'(r_banks);
        end
    end

    assign w_req_ok     = 32'(i_req.requester) < 32'(w_nb);
    assign w_mask_banks = i_req.busy_mask[bfla_pkg::BUSY_BANKS-1:0];
    assign w_node       = NODE_MOD[i_req.node_index];
    assign w_cnt_sat    = (32'(i_req.populate_count) > NODE_COUNT) ?
                          CNTW'(NODE_COUNT) : CNTW'(i_req.populate_count);
    assign w_quota      = r_q + CNTW'((32'(r_b) < 32'(r_rem)) ? 1 : 0);
    assign w_can_out    = !r_ov || o_rsp.ready;

    always_comb begin
        for (int b = 0; b < NUM_BANKS; b++) begin
            w_busy[b] = (b < bfla_pkg::BUSY_BANKS) &&
                        w_mask_banks[bfla_pkg::BUSY_IW'(b)];
            w_elig[b] = (b < 32'(w_nb)) && !w_busy[b] &&
                        ((i_req.opcode == bfla_pkg::OP_PUSH) || r_ne[b]);
        end
    end

    // Wrap-around search: first eligible bank at or after the requester, else the lowest.
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (!w_found && w_elig[b] && (b >= 32'(i_req.requester))) begin
                w_found = 1'b1;
                w_sel   = BW'(b);
            end
        end
        for (int b = 0; b < NUM_BANKS; b++) begin
            if (!w_found && w_elig[b]) begin
                w_found = 1'b1;
                w_sel   = BW'(b);
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_ne      = r_ne;
        n_ovf_ne  = r_ovf_ne;
        n_ovf_idx = r_ovf_idx;
        n_bank    = r_bank;
        n_ovf     = r_ovf;
        n_node    = r_node;
        n_q       = r_q;
        n_rem     = r_rem;
        n_left    = r_left;
        n_b       = r_b;
        n_next    = r_next;
        n_cur     = r_cur;
        n_rstat   = r_rstat;
        n_ov      = r_ov && !o_rsp.ready;
        n_status  = r_status;
        n_nout    = r_nout;
        n_used    = r_used;
        w_hre     = 1'b0;
        w_hra     = r_bank;
        w_hwe     = 1'b0;
        w_hwd     = r_node;
        w_lre     = 1'b0;
        w_lra     = r_node;
        w_lwe     = 1'b0;
        w_lwa     = r_node;
        w_lwd     = r_cur;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_node = w_node;
                    n_bank = w_sel;
                    n_ovf  = !w_found;
                    if (!w_req_ok) begin
                        n_rstat = bfla_pkg::ST_REJECT;
                        n_state = S_REPLY;
                    end else begin
                        unique case (i_req.opcode)
                            bfla_pkg::OP_PUSH: begin
                                w_hre   = w_found;
                                w_hra   = w_sel;
                                n_state = S_PUSH;
                            end
                            bfla_pkg::OP_POP: begin
                                if (w_found) begin
                                    w_hre   = 1'b1;
                                    w_hra   = w_sel;
                                    n_state = S_PHEAD;
                                end else if (r_ovf_ne &&
                                             !i_req.busy_mask[bfla_pkg::OVF_BUSY_BIT]) begin
                                    n_state = S_PHEAD;
                                end else begin
                                    n_rstat = bfla_pkg::ST_EMPTY;
                                    n_state = S_REPLY;
                                end
                            end
                            bfla_pkg::OP_POPULATE: begin
                                n_q     = '0;
                                n_rem   = w_cnt_sat;
                                n_state = S_DIV;
                            end
                            default: begin
                                n_rstat = bfla_pkg::ST_DONE;
                                n_state = S_REPLY;
                            end
                        endcase
                    end
                end
            end
            S_PUSH: begin
                if (w_can_out) begin
                    w_lwe = 1'b1;
                    w_lwa = r_node;
                    if (r_ovf) begin
                        w_lwd     = {!r_ovf_ne, r_ovf_idx};
                        n_ovf_ne  = 1'b1;
                        n_ovf_idx = r_node;
                        n_used    = bfla_pkg::LIST_OVF;
                    end else begin
                        w_lwd        = {!r_ne[r_bank], r_hrd};
                        w_hwe        = 1'b1;
                        w_hwd        = r_node;
                        n_ne[r_bank] = 1'b1;
                        n_used       = bfla_pkg::t_list'(r_bank);
                    end
                    n_ov     = 1'b1;
                    n_status = bfla_pkg::ST_DONE;
                    n_nout   = '0;
                    n_state  = S_IDLE;
                end
            end
            S_PHEAD: begin
                w_lre   = 1'b1;
                w_lra   = r_ovf ? r_ovf_idx : r_hrd;
                n_node  = r_ovf ? r_ovf_idx : r_hrd;
                n_state = S_PLINK;
            end
            S_PLINK: begin
                if (w_can_out) begin
                    if (r_ovf) begin
                        n_ovf_ne  = !r_lrd[NW];
                        n_ovf_idx = r_lrd[NW-1:0];
                        n_used    = bfla_pkg::LIST_OVF;
                    end else begin
                        w_hwe        = 1'b1;
                        w_hwd        = r_lrd[NW-1:0];
                        n_ne[r_bank] = !r_lrd[NW];
                        n_used       = bfla_pkg::t_list'(r_bank);
                    end
                    n_ov     = 1'b1;
                    n_status = bfla_pkg::ST_DONE;
                    n_nout   = bfla_pkg::t_node_out'(r_node);
                    n_state  = S_IDLE;
                end
            end
            S_DIV: begin
                if (32'(r_rem) >= 32'(w_nb)) begin
                    n_rem = r_rem - CNTW'(w_nb);
                    n_q   = r_q + CNTW'(1);
                end else begin
                    n_b     = '0;
                    n_next  = '0;
                    n_state = S_PBANK;
                end
            end
            S_PBANK: begin
                if (32'(r_b) >= 32'(w_nb)) begin
                    n_rstat = bfla_pkg::ST_DONE;
                    n_state = S_REPLY;
                end else if (w_quota == '0) begin
                    n_b = r_b + BW1'(1);
                end else begin
                    w_hre   = 1'b1;
                    w_hra   = r_b[BW-1:0];
                    n_bank  = r_b[BW-1:0];
                    n_left  = w_quota;
                    n_state = S_PGET;
                end
            end
            S_PGET: begin
                n_cur   = {!r_ne[r_bank], r_hrd};
                n_state = S_PFILL;
            end
            S_PFILL: begin
                w_lwe        = 1'b1;
                w_lwa        = r_next;
                w_lwd        = r_cur;
                w_hwe        = 1'b1;
                w_hwd        = r_next;
                n_ne[r_bank] = 1'b1;
                n_cur        = {1'b0, r_next};
                n_next       = r_next + NW'(1);
                if (r_left == CNTW'(1)) begin
                    n_b     = r_b + BW1'(1);
                    n_state = S_PBANK;
                end else begin
                    n_left = r_left - CNTW'(1);
                end
            end
            S_REPLY: begin
                if (w_can_out) begin
                    n_ov     = 1'b1;
                    n_status = r_rstat;
                    n_nout   = '0;
                    n_used   = bfla_pkg::LIST_NONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_hwe) begin
            r_head_mem[r_bank] <= w_hwd;
        end
        if (w_hre) begin
            r_hrd <= r_head_mem[w_hra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lwe) begin
            r_link_mem[w_lwa] <= w_lwd;
        end
        if (w_lre) begin
            r_lrd <= r_link_mem[w_lra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_banks  <= bfla_pkg::BANKS_RESET;
            r_ne     <= '0;
            r_ovf_ne <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ne     <= n_ne;
            r_ovf_ne <= n_ovf_ne;
            r_ov     <= n_ov;
            if (w_cfg_wr) begin
                r_banks <= pwdata[$bits(bfla_pkg::t_banks)-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovf_idx <= n_ovf_idx;
        r_bank    <= n_bank;
        r_ovf     <= n_ovf;
        r_node    <= n_node;
        r_q       <= n_q;
        r_rem     <= n_rem;
        r_left    <= n_left;
        r_b       <= n_b;
        r_next    <= n_next;
        r_cur     <= n_cur;
        r_rstat   <= n_rstat;
        r_status  <= n_status;
        r_nout    <= n_nout;
        r_used    <= n_used;
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ov;
    assign o_rsp.status    = r_status;
    assign o_rsp.node_out  = r_nout;
    assign o_rsp.list_used = r_used;

    assign w_req_xfer  = i_req.valid && i_req.ready;
    assign w_pop_bank  = (r_state == S_PHEAD) && !r_ovf;
    assign w_rsp_fail  = r_ov && (r_status != bfla_pkg::ST_DONE);
    assign w_rsp_clean = (r_nout == '0) && (r_used == bfla_pkg::LIST_NONE);

    `BFLA_ASSERT_NEXT(a_accept_leaves_idle, w_req_xfer, r_state != S_IDLE, "no start")
    `BFLA_ASSERT_IMP(a_pop_bank_nonempty, w_pop_bank, r_ne[r_bank], "pop of an empty bank")
    `BFLA_ASSERT_IMP(a_fill_left, r_state == S_PFILL, r_left != '0, "fill with none left")
    `BFLA_ASSERT_IMP(a_empty_fields, w_rsp_fail, w_rsp_clean, "failed response carries a node")

endmodule
